### sv/lpmp_pkg.sv
`timescale 1ns / 1ps
// lpmp_pkg: shared constants and types for the length-prefixed message parser.
// No dependencies.
package lpmp_pkg;

  localparam int ByteW  = 8;
  localparam int PhaseW = 3;
  localparam int RoleW  = 3;
  localparam int ErrW   = 3;

  // parse phases
  localparam logic [PhaseW-1:0] PH_CODE      = 3'd0;
  localparam logic [PhaseW-1:0] PH_LEN       = 3'd1;
  localparam logic [PhaseW-1:0] PH_DATA      = 3'd2;
  localparam logic [PhaseW-1:0] PH_USER_LEN  = 3'd3;
  localparam logic [PhaseW-1:0] PH_USER_DATA = 3'd4;
  localparam logic [PhaseW-1:0] PH_STATUS    = 3'd5;
  localparam logic [PhaseW-1:0] PH_TRAIL     = 3'd6;

  // byte roles
  localparam logic [RoleW-1:0] ROLE_CODE   = 3'd0;
  localparam logic [RoleW-1:0] ROLE_LEN    = 3'd1;
  localparam logic [RoleW-1:0] ROLE_DATA   = 3'd2;
  localparam logic [RoleW-1:0] ROLE_STATUS = 3'd3;
  localparam logic [RoleW-1:0] ROLE_TRAIL  = 3'd4;

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE         = 3'd0;
  localparam logic [ErrW-1:0] ERR_NO_USER_LEN  = 3'd1;
  localparam logic [ErrW-1:0] ERR_USER_TRUNC   = 3'd2;
  localparam logic [ErrW-1:0] ERR_NO_STATUS    = 3'd3;
  localparam logic [ErrW-1:0] ERR_FIELD_TRUNC  = 3'd4;

  localparam logic [ByteW-1:0] SPECIAL_CODE = 8'd3;
  localparam logic [ByteW-1:0] COUNT_MAX    = 8'd255;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  remaining;
    logic [ByteW-1:0]  counter;
  } parse_state_t;

  typedef struct packed {
    logic [RoleW-1:0] role;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] fnum;
    logic             done;
    logic             last;
    logic [ErrW-1:0]  err;
  } result_t;

  localparam parse_state_t STATE_RESET = '{phase: PH_CODE, remaining: '0, counter: '0};

endpackage

### sv/lpmp_step.sv
`timescale 1ns / 1ps
// lpmp_step: combinational per-byte decode; next parse state and result item.
// Depends on lpmp_pkg.
module lpmp_step
  import lpmp_pkg::*;
(
  input  parse_state_t     cur,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  output parse_state_t     nxt,
  output result_t          res
);

  logic [ByteW-1:0] cnt_inc;
  logic [ByteW-1:0] rem_dec;
  logic             user;

  assign cnt_inc = (cur.counter == COUNT_MAX) ? COUNT_MAX : cur.counter + 8'd1;
  assign rem_dec = (cur.remaining != '0) ? cur.remaining - 8'd1 : cur.remaining;
  assign user    = (cur.phase == PH_USER_LEN) || (cur.phase == PH_USER_DATA);

  always_comb begin
    parse_state_t s;
    s         = cur;
    res.role  = ROLE_CODE;
    res.value = data_byte;
    res.fnum  = '0;
    res.done  = 1'b0;
    res.last  = last_byte;
    res.err   = ERR_NONE;

    case (cur.phase)
      PH_LEN, PH_USER_LEN: begin
        res.role = ROLE_LEN;
        res.fnum = cur.counter;
        if (data_byte == '0) begin
          res.done  = 1'b1;
          s.counter = cnt_inc;
          s.phase   = user ? PH_STATUS : PH_LEN;
          if (last_byte && user) res.err = ERR_NO_STATUS;
        end else begin
          s.remaining = data_byte;
          s.phase     = user ? PH_USER_DATA : PH_DATA;
          if (last_byte) res.err = user ? ERR_USER_TRUNC : ERR_FIELD_TRUNC;
        end
      end
      PH_DATA, PH_USER_DATA: begin
        res.role    = ROLE_DATA;
        res.fnum    = cur.counter;
        s.remaining = rem_dec;
        if (rem_dec == '0) begin
          res.done  = 1'b1;
          s.counter = cnt_inc;
          s.phase   = user ? PH_STATUS : PH_LEN;
          if (last_byte && user) res.err = ERR_NO_STATUS;
        end else if (last_byte) begin
          res.err = user ? ERR_USER_TRUNC : ERR_FIELD_TRUNC;
        end
      end
      PH_STATUS: begin
        res.role  = ROLE_STATUS;
        res.fnum  = cur.counter;
        res.done  = 1'b1;
        s.counter = cnt_inc;
        s.phase   = PH_TRAIL;
      end
      PH_TRAIL: begin
        res.role = ROLE_TRAIL;
      end
      default: begin
        // code byte; unused phase codes land here too
        s.counter   = '0;
        s.remaining = '0;
        if (data_byte == SPECIAL_CODE) begin
          s.phase = PH_USER_LEN;
          if (last_byte) res.err = ERR_NO_USER_LEN;
        end else begin
          s.phase = PH_LEN;
        end
      end
    endcase

    nxt = last_byte ? STATE_RESET : s;
  end

endmodule

### sv/lpmp_out_reg.sv
`timescale 1ns / 1ps
// lpmp_out_reg: result register between the decode logic and the output channel.
// Depends on lpmp_pkg.
module lpmp_out_reg
  import lpmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    full,
  input  logic    take,
  output result_t res_q
);

  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

  assign res_q = res;

endmodule

### sv/length_prefixed_message_parser.sv
`timescale 1ns / 1ps
// Length-prefixed message parser: one result per byte.
// The result of an accepted byte appears on the output register in the next cycle.
// Throughput: 1 byte per cycle; in_ready stays high while the result register
// is empty or being drained in the same cycle.
// Reset (rst, synchronous): parser returns to "expecting message code", output empty.
module length_prefixed_message_parser
  import lpmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RoleW-1:0] byte_role,
  output logic [ByteW-1:0] byte_value,
  output logic [ByteW-1:0] field_number,
  output logic             field_complete,
  output logic             message_end,
  output logic [ErrW-1:0]  error_code
);

  parse_state_t state;
  parse_state_t state_next;
  result_t      res_d;
  result_t      res_q;
  logic         accept;

  // A byte can enter whenever the result register frees up this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Per-byte decode: phase, owed data bytes and saturating field count.
  lpmp_step u_step (
    .cur       (state),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .nxt       (state_next),
    .res       (res_d)
  );

  // Parser state advances only on an accepted byte; the last byte of a
  // message returns it to the code phase (handled inside the step logic).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  lpmp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .res_in (res_d),
    .full   (out_valid),
    .take   (out_ready),
    .res_q  (res_q)
  );

  assign byte_role      = res_q.role;
  assign byte_value     = res_q.value;
  assign field_number   = res_q.fnum;
  assign field_complete = res_q.done;
  assign message_end    = res_q.last;
  assign error_code     = res_q.err;

`ifndef SYNTH
  // errors are only reported on the final byte of a message
  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_NONE) |-> message_end)
    else $error("error code without message end");

  // code and trailing bytes carry field 0 and never complete a field
  a_code_trail_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_role == ROLE_CODE || byte_role == ROLE_TRAIL)
      |-> (field_number == '0) && !field_complete)
    else $error("code or trailing byte tagged with a field");

  // after a final byte is accepted, the parser is back at the code phase
  a_reset_after_end: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> (state == STATE_RESET))
    else $error("parser state not cleared after message end");

  // status byte always finishes a field
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_role == ROLE_STATUS) |-> field_complete)
    else $error("status byte did not complete its field");
`endif

endmodule
